@@ sv/pttas_pkg.sv @@
// Shared types, codes and a helper function for the pan and tilt track and search block.
package pttas_pkg;

    typedef logic signed [12:0] t_ang;

    localparam t_ang ANG_MAX = 13'sd4095;
    localparam t_ang ANG_MIN = -13'sd4096;

    localparam logic [2:0] PH_ONE   = 3'd0;
    localparam logic [2:0] PH_TWO   = 3'd1;
    localparam logic [2:0] PH_THREE = 3'd2;
    localparam logic [2:0] PH_FOUR  = 3'd3;
    localparam logic [2:0] PH_NONE  = 3'd4;

    localparam logic [2:0] REG_PAN_PROP    = 3'd0;
    localparam logic [2:0] REG_PAN_DIFF    = 3'd1;
    localparam logic [2:0] REG_TILT_PROP   = 3'd2;
    localparam logic [2:0] REG_TILT_DIFF   = 3'd3;
    localparam logic [2:0] REG_PAN_LEFT    = 3'd4;
    localparam logic [2:0] REG_PAN_RIGHT   = 3'd5;
    localparam logic [2:0] REG_TILT_TOP    = 3'd6;
    localparam logic [2:0] REG_TILT_BOTTOM = 3'd7;

    localparam logic [15:0] RST_PROP_GAIN = 16'd410;
    localparam logic [15:0] RST_DIFF_GAIN = 16'd901;
    localparam t_ang RST_LEFT   = 13'sd480;
    localparam t_ang RST_RIGHT  = -13'sd480;
    localparam t_ang RST_TOP    = 13'sd960;
    localparam t_ang RST_BOTTOM = -13'sd400;

    typedef enum logic [2:0] {
        OP_MOVE,
        OP_CLEAR,
        OP_NEAR,
        OP_FAR,
        OP_INIT,
        OP_STEP
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOVE,
        ST_CLEAR,
        ST_TRK_ERR,
        ST_TRK_MUL1,
        ST_TRK_MUL2,
        ST_TRK_ACC,
        ST_TRK_APPLY,
        ST_CLAMP,
        ST_DIV_SETUP,
        ST_DIV_ITER,
        ST_INIT_FIN,
        ST_STEP_ADD,
        ST_STEP_CLAMP,
        ST_STEP_PHASE,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MOVE,
        CMD_CLEAR,
        CMD_TRK_ERR,
        CMD_MUL1,
        CMD_MUL2,
        CMD_ACC,
        CMD_APPLY,
        CMD_CLAMP,
        CMD_DIV_SETUP,
        CMD_DIV_ITER,
        CMD_INIT_FIN,
        CMD_STEP_ADD,
        CMD_STEP_PHASE
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] term;
        logic       out_load;
    } t_ctrl;

    typedef struct packed {
        logic init_clamp;
    } t_stat;

    typedef struct packed {
        logic [2:0] opcode;
        t_ang       error_x;
        t_ang       error_y;
        t_ang       target_pan;
        t_ang       target_tilt;
        logic [2:0] start_phase;
    } t_item;

    typedef struct packed {
        logic [3:0][15:0] gain;
        t_ang             left;
        t_ang             right;
        t_ang             top;
        t_ang             bottom;
    } t_cfg;

    function automatic t_ang sat_ang(input logic signed [39:0] v);
        t_ang r;
        if (v > 40'sd4095) begin
            r = ANG_MAX;
        end else if (v < -40'sd4096) begin
            r = ANG_MIN;
        end else begin
            r = v[12:0];
        end
        return r;
    endfunction

endpackage

@@ sv/pttas_ctrl.sv @@
// Sequencing state machine: steps the datapath through each opcode.
module pttas_ctrl #(
    parameter int DIV_STEPS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [2:0]        i_opcode,
    input  pttas_pkg::t_stat  i_stat,
    input  logic              i_out_free,
    output logic              o_in_ready,
    output pttas_pkg::t_ctrl  o_ctrl
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    pttas_pkg::t_state r_state, n_state;
    logic [1:0]       r_term, n_term;
    logic [CNT_W-1:0] r_div_cnt, n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pttas_pkg::ST_IDLE;
            r_term    <= '0;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_term    <= n_term;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_term    = r_term;
        n_div_cnt = r_div_cnt;
        unique case (r_state)
            pttas_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (pttas_pkg::t_op'(i_opcode))
                        pttas_pkg::OP_MOVE:  n_state = pttas_pkg::ST_MOVE;
                        pttas_pkg::OP_CLEAR: n_state = pttas_pkg::ST_CLEAR;
                        pttas_pkg::OP_NEAR:  n_state = pttas_pkg::ST_TRK_ERR;
                        pttas_pkg::OP_FAR:   n_state = pttas_pkg::ST_TRK_ERR;
                        pttas_pkg::OP_INIT:  n_state = pttas_pkg::ST_DIV_SETUP;
                        pttas_pkg::OP_STEP:  n_state = pttas_pkg::ST_STEP_ADD;
                        default:             n_state = pttas_pkg::ST_DONE;
                    endcase
                end
            end
            pttas_pkg::ST_MOVE:  n_state = pttas_pkg::ST_CLAMP;
            pttas_pkg::ST_CLEAR: n_state = pttas_pkg::ST_DONE;
            pttas_pkg::ST_TRK_ERR: begin
                n_term  = '0;
                n_state = pttas_pkg::ST_TRK_MUL1;
            end
            pttas_pkg::ST_TRK_MUL1: n_state = pttas_pkg::ST_TRK_MUL2;
            pttas_pkg::ST_TRK_MUL2: n_state = pttas_pkg::ST_TRK_ACC;
            pttas_pkg::ST_TRK_ACC: begin
                n_term = r_term + 2'd1;
                if (r_term == 2'd3) begin
                    n_state = pttas_pkg::ST_TRK_APPLY;
                end else begin
                    n_state = pttas_pkg::ST_TRK_MUL1;
                end
            end
            pttas_pkg::ST_TRK_APPLY: n_state = pttas_pkg::ST_CLAMP;
            pttas_pkg::ST_CLAMP:     n_state = pttas_pkg::ST_DONE;
            pttas_pkg::ST_DIV_SETUP: begin
                n_div_cnt = '0;
                n_state   = pttas_pkg::ST_DIV_ITER;
            end
            pttas_pkg::ST_DIV_ITER: begin
                n_div_cnt = r_div_cnt + CNT_W'(1);
                if (r_div_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = pttas_pkg::ST_INIT_FIN;
                end
            end
            pttas_pkg::ST_INIT_FIN: begin
                if (i_stat.init_clamp) begin
                    n_state = pttas_pkg::ST_CLAMP;
                end else begin
                    n_state = pttas_pkg::ST_DONE;
                end
            end
            pttas_pkg::ST_STEP_ADD:   n_state = pttas_pkg::ST_STEP_CLAMP;
            pttas_pkg::ST_STEP_CLAMP: n_state = pttas_pkg::ST_STEP_PHASE;
            pttas_pkg::ST_STEP_PHASE: n_state = pttas_pkg::ST_DONE;
            pttas_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = pttas_pkg::ST_IDLE;
                end
            end
            default: n_state = pttas_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_ctrl.cmd      = pttas_pkg::CMD_NONE;
        o_ctrl.term     = r_term;
        o_ctrl.out_load = 1'b0;
        unique case (r_state)
            pttas_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.cmd = pttas_pkg::CMD_LOAD;
                end
            end
            pttas_pkg::ST_MOVE:       o_ctrl.cmd = pttas_pkg::CMD_MOVE;
            pttas_pkg::ST_CLEAR:      o_ctrl.cmd = pttas_pkg::CMD_CLEAR;
            pttas_pkg::ST_TRK_ERR:    o_ctrl.cmd = pttas_pkg::CMD_TRK_ERR;
            pttas_pkg::ST_TRK_MUL1:   o_ctrl.cmd = pttas_pkg::CMD_MUL1;
            pttas_pkg::ST_TRK_MUL2:   o_ctrl.cmd = pttas_pkg::CMD_MUL2;
            pttas_pkg::ST_TRK_ACC:    o_ctrl.cmd = pttas_pkg::CMD_ACC;
            pttas_pkg::ST_TRK_APPLY:  o_ctrl.cmd = pttas_pkg::CMD_APPLY;
            pttas_pkg::ST_CLAMP:      o_ctrl.cmd = pttas_pkg::CMD_CLAMP;
            pttas_pkg::ST_DIV_SETUP:  o_ctrl.cmd = pttas_pkg::CMD_DIV_SETUP;
            pttas_pkg::ST_DIV_ITER:   o_ctrl.cmd = pttas_pkg::CMD_DIV_ITER;
            pttas_pkg::ST_INIT_FIN:   o_ctrl.cmd = pttas_pkg::CMD_INIT_FIN;
            pttas_pkg::ST_STEP_ADD:   o_ctrl.cmd = pttas_pkg::CMD_STEP_ADD;
            pttas_pkg::ST_STEP_CLAMP: o_ctrl.cmd = pttas_pkg::CMD_CLAMP;
            pttas_pkg::ST_STEP_PHASE: o_ctrl.cmd = pttas_pkg::CMD_STEP_PHASE;
            pttas_pkg::ST_DONE:       o_ctrl.out_load = i_out_free;
            default:                  o_ctrl.cmd = pttas_pkg::CMD_NONE;
        endcase
    end

endmodule

@@ sv/pttas_dp.sv @@
// Datapath: angle state, shared multiplier, restoring divider, clamp and search rules.
module pttas_dp #(
    parameter int ANGLE_FRAC_BITS = 4,
    parameter int COUNT_WIDTH     = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pttas_pkg::t_ctrl  i_ctrl,
    input  pttas_pkg::t_item  i_item,
    input  pttas_pkg::t_cfg   i_cfg,
    output pttas_pkg::t_stat  o_stat,
    output pttas_pkg::t_ang   o_pan,
    output pttas_pkg::t_ang   o_tilt,
    output logic [2:0]        o_phase,
    output logic [15:0]       o_count
);

    localparam int PAN_STEP  = 5 << ANGLE_FRAC_BITS;
    localparam int TILT_INIT = 10 << ANGLE_FRAC_BITS;
    localparam int EDGE      = 70 << ANGLE_FRAC_BITS;
    localparam int SHIFT     = 32 - ANGLE_FRAC_BITS;
    localparam int NUM_MUL   = 20 << ANGLE_FRAC_BITS;
    localparam int AN_W      = 18 + ANGLE_FRAC_BITS;
    localparam int NUM_W     = AN_W + 1;
    localparam int DV_W      = AN_W + 2;
    localparam logic [58:0] ROUND = 59'(1) << (SHIFT - 1);
    localparam pttas_pkg::t_ang PSTEP_POS = 13'(PAN_STEP);
    localparam pttas_pkg::t_ang PSTEP_NEG = 13'(-PAN_STEP);
    localparam logic [COUNT_WIDTH+1:0] CNT_MAX = {2'b00, {COUNT_WIDTH{1'b1}}};

    pttas_pkg::t_ang r_pan, r_tilt, r_perr, r_terr, r_pinc, r_tinc, r_step, r_bot;
    logic signed [13:0] r_pchg, r_tchg;
    logic [2:0]  r_phase;
    logic [COUNT_WIDTH-1:0] r_count;
    pttas_pkg::t_ang r_ex, r_ey, r_tp, r_tt;
    logic [2:0]  r_sp;
    logic        r_near;
    logic [57:0] r_prod;
    logic signed [37:0] r_acc_pan, r_acc_tilt;
    logic [DV_W-1:0] r_dvd;
    logic [13:0] r_rem;
    logic [14:0] r_dvs;
    logic        r_qneg, r_num_pos, r_num_neg, r_den_zero;

    function automatic pttas_pkg::t_ang eff_bot(input pttas_pkg::t_ang pan,
                                                input pttas_pkg::t_ang bot_cfg);
        logic signed [31:0] p;
        p = 32'(pan);
        if (p > EDGE || p < -EDGE) begin
            return '0;
        end
        return bot_cfg;
    endfunction

    // Clamp of the current angles.
    pttas_pkg::t_ang cl_pan, cl_tilt, cl_bot;
    always_comb begin
        cl_pan = r_pan;
        if (r_pan > i_cfg.left) begin
            cl_pan = i_cfg.left;
        end else if (r_pan < i_cfg.right) begin
            cl_pan = i_cfg.right;
        end
        cl_bot  = eff_bot(cl_pan, i_cfg.bottom);
        cl_tilt = r_tilt;
        if (r_tilt > i_cfg.top) begin
            cl_tilt = i_cfg.top;
        end else if (r_tilt < cl_bot) begin
            cl_tilt = cl_bot;
        end
    end

    // Tracking term operands and the shared multiplier.
    logic signed [13:0] e_sel;
    logic [13:0] e_mag;
    logic [15:0] g_sel;
    logic [28:0] mul_a, mul_b;
    logic [57:0] mul_p;
    always_comb begin
        unique case (i_ctrl.term)
            2'd0:    e_sel = 14'(r_perr);
            2'd1:    e_sel = r_pchg;
            2'd2:    e_sel = 14'(r_terr);
            default: e_sel = r_tchg;
        endcase
        g_sel = i_cfg.gain[i_ctrl.term];
        e_mag = e_sel[13] ? 14'(-e_sel) : 14'(e_sel);
        if (i_ctrl.cmd == pttas_pkg::CMD_MUL2) begin
            mul_a = r_prod[28:0];
            mul_b = r_prod[28:0];
        end else begin
            mul_a = 29'(e_mag);
            mul_b = 29'(g_sel);
        end
    end
    assign mul_p = mul_a * mul_b;

    logic [58:0] rnd_sum, rnd_shift;
    logic signed [36:0] term_s;
    logic signed [37:0] term_w;
    always_comb begin
        rnd_sum   = 59'(r_prod) + ROUND;
        rnd_shift = rnd_sum >> SHIFT;
        term_s    = $signed({1'b0, rnd_shift[35:0]});
        if (e_sel[13]) begin
            term_s = -term_s;
        end
        if (!i_ctrl.term[0]) begin
            term_w = r_near ? (38'(term_s) <<< 1) : 38'(term_s);
        end else begin
            term_w = r_near ? 38'(term_s) : '0;
        end
    end

    // Search init: step size numerator and divisor.
    pttas_pkg::t_ang    div_bot;
    logic signed [13:0] div_diff, div_den;
    logic signed [NUM_W-1:0] div_num;
    logic [AN_W-1:0] div_an;
    logic [13:0] div_ad;
    always_comb begin
        div_bot  = eff_bot(r_pan, i_cfg.bottom);
        div_diff = 14'(i_cfg.top) - 14'(div_bot);
        div_num  = NUM_W'(div_diff) * NUM_W'(NUM_MUL);
        div_den  = 14'(i_cfg.left) - 14'(i_cfg.right);
        div_an   = div_num[NUM_W-1] ? AN_W'(-div_num) : AN_W'(div_num);
        div_ad   = div_den[13] ? 14'(-div_den) : 14'(div_den);
    end

    logic [14:0] rem_sh, rem_nx;
    logic        rem_ge;
    always_comb begin
        rem_sh = {r_rem, r_dvd[DV_W-1]};
        rem_ge = (rem_sh >= r_dvs);
        rem_nx = rem_ge ? (rem_sh - r_dvs) : rem_sh;
    end

    logic signed [39:0] q_s;
    pttas_pkg::t_ang new_step;
    logic [2:0] sp_cl;
    always_comb begin
        q_s = 40'(r_dvd);
        if (r_qneg) begin
            q_s = -q_s;
        end
        if (r_den_zero) begin
            new_step = r_num_pos ? pttas_pkg::ANG_MAX :
                       (r_num_neg ? pttas_pkg::ANG_MIN : '0);
        end else begin
            new_step = pttas_pkg::sat_ang(q_s);
        end
        sp_cl = (r_sp > pttas_pkg::PH_NONE) ? pttas_pkg::PH_NONE : r_sp;
    end

    assign o_stat.init_clamp = (sp_cl == pttas_pkg::PH_TWO) || (sp_cl == pttas_pkg::PH_FOUR);

    // Search phase rules after a step.
    pttas_pkg::t_ang ph_pan, ph_pinc, ph_tinc, up, down;
    logic [2:0] ph_next;
    logic corner_l, corner_r;
    logic [COUNT_WIDTH+1:0] cnt_sum;
    always_comb begin
        up      = r_step;
        down    = pttas_pkg::sat_ang(-40'(r_step));
        ph_pan  = r_pan;
        ph_pinc = r_pinc;
        ph_tinc = r_tinc;
        ph_next = r_phase;
        unique case (r_phase)
            pttas_pkg::PH_ONE: begin
                ph_pan = i_cfg.left;
                if (r_tilt >= i_cfg.top) begin
                    ph_next = pttas_pkg::PH_TWO;
                end else begin
                    ph_pinc = '0;
                    ph_tinc = up;
                end
            end
            pttas_pkg::PH_TWO: begin
                ph_pinc = PSTEP_NEG;
                if (r_tilt >= i_cfg.top) begin
                    ph_tinc = down;
                end else if (r_tilt <= r_bot) begin
                    ph_tinc = up;
                end
                if (r_pan <= i_cfg.right && r_tilt >= i_cfg.top) begin
                    ph_next = pttas_pkg::PH_THREE;
                end
            end
            pttas_pkg::PH_THREE: begin
                ph_pan = i_cfg.right;
                if (r_tilt <= r_bot) begin
                    ph_next = pttas_pkg::PH_FOUR;
                end else begin
                    ph_pinc = '0;
                    ph_tinc = down;
                end
            end
            pttas_pkg::PH_FOUR: begin
                ph_pinc = PSTEP_POS;
                if (r_tilt >= i_cfg.top) begin
                    ph_tinc = down;
                end else if (r_tilt <= r_bot) begin
                    ph_tinc = up;
                end
                if (r_pan >= i_cfg.left && r_tilt <= r_bot) begin
                    ph_next = pttas_pkg::PH_ONE;
                end
            end
            default: ph_next = r_phase;
        endcase
        corner_l = (ph_pan == i_cfg.left) && (r_tilt >= i_cfg.top);
        corner_r = (ph_pan == i_cfg.right) && (r_tilt <= r_bot);
        cnt_sum  = {2'b00, r_count} + (COUNT_WIDTH+2)'(corner_l)
                 + (COUNT_WIDTH+2)'(corner_r);
        if (cnt_sum > CNT_MAX) begin
            cnt_sum = CNT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan      <= '0;
            r_tilt     <= '0;
            r_perr     <= '0;
            r_terr     <= '0;
            r_pchg     <= '0;
            r_tchg     <= '0;
            r_pinc     <= '0;
            r_tinc     <= 13'(TILT_INIT);
            r_step     <= '0;
            r_phase    <= pttas_pkg::PH_NONE;
            r_count    <= '0;
            r_bot      <= '0;
            r_near     <= 1'b0;
            r_qneg     <= 1'b0;
            r_num_pos  <= 1'b0;
            r_num_neg  <= 1'b0;
            r_den_zero <= 1'b0;
        end else begin
            unique case (i_ctrl.cmd)
                pttas_pkg::CMD_LOAD: begin
                    r_near <= (i_item.opcode == pttas_pkg::OP_NEAR);
                end
                pttas_pkg::CMD_MOVE: begin
                    r_pan  <= r_tp;
                    r_tilt <= r_tt;
                end
                pttas_pkg::CMD_CLEAR: begin
                    r_perr <= '0;
                    r_terr <= '0;
                    r_pchg <= '0;
                    r_tchg <= '0;
                end
                pttas_pkg::CMD_TRK_ERR: begin
                    r_pchg <= 14'(r_ex) - 14'(r_perr);
                    r_tchg <= 14'(r_ey) - 14'(r_terr);
                    r_perr <= r_ex;
                    r_terr <= r_ey;
                end
                pttas_pkg::CMD_APPLY: begin
                    r_pan  <= pttas_pkg::sat_ang(40'(r_pan) + 40'(r_acc_pan));
                    r_tilt <= pttas_pkg::sat_ang(40'(r_tilt) + 40'(r_acc_tilt));
                end
                pttas_pkg::CMD_CLAMP: begin
                    r_pan  <= cl_pan;
                    r_tilt <= cl_tilt;
                    r_bot  <= cl_bot;
                end
                pttas_pkg::CMD_DIV_SETUP: begin
                    r_qneg     <= div_num[NUM_W-1] != div_den[13];
                    r_num_pos  <= !div_num[NUM_W-1] && (div_num != '0);
                    r_num_neg  <= div_num[NUM_W-1];
                    r_den_zero <= (div_den == '0);
                end
                pttas_pkg::CMD_INIT_FIN: begin
                    r_step  <= new_step;
                    r_phase <= sp_cl;
                    r_count <= '0;
                    if (sp_cl == pttas_pkg::PH_TWO) begin
                        r_pinc <= PSTEP_NEG;
                        r_tinc <= pttas_pkg::sat_ang(-40'(new_step));
                    end else if (sp_cl == pttas_pkg::PH_FOUR) begin
                        r_pinc <= PSTEP_POS;
                        r_tinc <= new_step;
                    end
                end
                pttas_pkg::CMD_STEP_ADD: begin
                    r_pan  <= pttas_pkg::sat_ang(40'(r_pan) + 40'(r_pinc));
                    r_tilt <= pttas_pkg::sat_ang(40'(r_tilt) + 40'(r_tinc));
                end
                pttas_pkg::CMD_STEP_PHASE: begin
                    r_pan   <= ph_pan;
                    r_pinc  <= ph_pinc;
                    r_tinc  <= ph_tinc;
                    r_phase <= ph_next;
                    r_count <= cnt_sum[COUNT_WIDTH-1:0];
                end
                default: r_near <= r_near;
            endcase
        end
    end

    // Operand and working registers without reset.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmd == pttas_pkg::CMD_LOAD) begin
            r_ex <= i_item.error_x;
            r_ey <= i_item.error_y;
            r_tp <= i_item.target_pan;
            r_tt <= i_item.target_tilt;
            r_sp <= i_item.start_phase;
        end
        if (i_ctrl.cmd == pttas_pkg::CMD_TRK_ERR) begin
            r_acc_pan  <= '0;
            r_acc_tilt <= '0;
        end else if (i_ctrl.cmd == pttas_pkg::CMD_ACC) begin
            if (i_ctrl.term[1]) begin
                r_acc_tilt <= r_acc_tilt + term_w;
            end else begin
                r_acc_pan <= r_acc_pan + term_w;
            end
        end
        if (i_ctrl.cmd == pttas_pkg::CMD_MUL1 || i_ctrl.cmd == pttas_pkg::CMD_MUL2) begin
            r_prod <= mul_p;
        end
        if (i_ctrl.cmd == pttas_pkg::CMD_DIV_SETUP) begin
            r_dvd <= DV_W'({div_an, 1'b0}) + DV_W'(div_ad);
            r_dvs <= {div_ad, 1'b0};
            r_rem <= '0;
        end else if (i_ctrl.cmd == pttas_pkg::CMD_DIV_ITER) begin
            r_rem <= rem_nx[13:0];
            r_dvd <= {r_dvd[DV_W-2:0], rem_ge};
        end
    end

    logic [COUNT_WIDTH+15:0] count_ext;
    assign count_ext = {16'b0, r_count};
    assign o_pan   = r_pan;
    assign o_tilt  = r_tilt;
    assign o_phase = r_phase;
    assign o_count = count_ext[15:0];

endmodule

@@ sv/pan_tilt_track_and_search.sv @@
// Top level of the pan and tilt track and search block: ports, registers and result beat.
// Tracking passes four squared terms through one shared multiplier; search init uses a
// restoring divider, one quotient bit per cycle, 20 + ANGLE_FRAC_BITS bits. One beat is in
// work at a time; the next is taken once the result sits in the output register. Reset is
// synchronous.
module pan_tilt_track_and_search #(
    parameter int ANGLE_FRAC_BITS = 4,
    parameter int COUNT_WIDTH     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // opcode, error_x, error_y, target_pan, target_tilt, start_phase
    input  logic [63:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pan_angle, tilt_angle, search_phase, search_cycles
    output logic [47:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DIV_STEPS = 20 + ANGLE_FRAC_BITS;

    pttas_pkg::t_cfg  r_cfg;
    pttas_pkg::t_item item;
    pttas_pkg::t_ctrl ctrl;
    pttas_pkg::t_stat stat;
    pttas_pkg::t_ang  pan, tilt;
    logic [2:0]  phase;
    logic [15:0] count;
    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic        out_free;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain[0] <= pttas_pkg::RST_PROP_GAIN;
            r_cfg.gain[1] <= pttas_pkg::RST_DIFF_GAIN;
            r_cfg.gain[2] <= pttas_pkg::RST_PROP_GAIN;
            r_cfg.gain[3] <= pttas_pkg::RST_DIFF_GAIN;
            r_cfg.left    <= pttas_pkg::RST_LEFT;
            r_cfg.right   <= pttas_pkg::RST_RIGHT;
            r_cfg.top     <= pttas_pkg::RST_TOP;
            r_cfg.bottom  <= pttas_pkg::RST_BOTTOM;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                pttas_pkg::REG_PAN_PROP:    r_cfg.gain[0] <= pwdata[15:0];
                pttas_pkg::REG_PAN_DIFF:    r_cfg.gain[1] <= pwdata[15:0];
                pttas_pkg::REG_TILT_PROP:   r_cfg.gain[2] <= pwdata[15:0];
                pttas_pkg::REG_TILT_DIFF:   r_cfg.gain[3] <= pwdata[15:0];
                pttas_pkg::REG_PAN_LEFT:    r_cfg.left    <= pwdata[12:0];
                pttas_pkg::REG_PAN_RIGHT:   r_cfg.right   <= pwdata[12:0];
                pttas_pkg::REG_TILT_TOP:    r_cfg.top     <= pwdata[12:0];
                pttas_pkg::REG_TILT_BOTTOM: r_cfg.bottom  <= pwdata[12:0];
                default:                    r_cfg.top     <= r_cfg.top;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pttas_pkg::REG_PAN_PROP:    prdata = {16'b0, r_cfg.gain[0]};
            pttas_pkg::REG_PAN_DIFF:    prdata = {16'b0, r_cfg.gain[1]};
            pttas_pkg::REG_TILT_PROP:   prdata = {16'b0, r_cfg.gain[2]};
            pttas_pkg::REG_TILT_DIFF:   prdata = {16'b0, r_cfg.gain[3]};
            pttas_pkg::REG_PAN_LEFT:    prdata = {19'b0, r_cfg.left};
            pttas_pkg::REG_PAN_RIGHT:   prdata = {19'b0, r_cfg.right};
            pttas_pkg::REG_TILT_TOP:    prdata = {19'b0, r_cfg.top};
            pttas_pkg::REG_TILT_BOTTOM: prdata = {19'b0, r_cfg.bottom};
            default:                    prdata = '0;
        endcase
    end

    always_comb begin
        item.opcode      = i_s_axis_tdata[2:0];
        item.error_x     = i_s_axis_tdata[15:3];
        item.error_y     = i_s_axis_tdata[28:16];
        item.target_pan  = i_s_axis_tdata[41:29];
        item.target_tilt = i_s_axis_tdata[54:42];
        item.start_phase = i_s_axis_tdata[57:55];
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    pttas_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_opcode   (item.opcode),
        .i_stat     (stat),
        .i_out_free (out_free),
        .o_in_ready (o_s_axis_tready),
        .o_ctrl     (ctrl)
    );

    pttas_dp #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_item  (item),
        .i_cfg   (r_cfg),
        .o_stat  (stat),
        .o_pan   (pan),
        .o_tilt  (tilt),
        .o_phase (phase),
        .o_count (count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_data <= {3'b000, count, phase, tilt, pan};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
